// File: rtl/ihtp_pkg.sv
package ihtp_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned FIELD_W = 7;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned DAYS_W  = 24;
    localparam int unsigned HOURS_W = 28;

    localparam logic [POS_W-1:0] TS_LENGTH    = 5'd16;
    localparam logic [POS_W-1:0] POS_YEAR_END = 5'd3;
    localparam logic [POS_W-1:0] POS_MON_END  = 5'd6;
    localparam logic [POS_W-1:0] POS_DAY_END  = 5'd9;
    localparam logic [POS_W-1:0] POS_DATE_SEP1 = 5'd4;
    localparam logic [POS_W-1:0] POS_DATE_SEP2 = 5'd7;
    localparam logic [POS_W-1:0] POS_TIME_SEP  = 5'd10;
    localparam logic [POS_W-1:0] POS_HOUR_SEP  = 5'd13;
    localparam logic [POS_W-1:0] POS_MIN_TENS  = 5'd14;
    localparam logic [POS_W-1:0] POS_MIN_ONES  = 5'd15;

    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [YEAR_W-1:0] EARLIEST_YEAR_RESET = 14'd1940;

    // year is biased by one era so the floor divisions stay non-negative
    localparam logic [YEAR_W-1:0] YEAR_BIAS  = 14'd400;
    // 719468 epoch shift plus the 146097 days of the bias era
    localparam logic [DAYS_W-1:0] EPOCH_BIAS = 24'd865565;
    // x / 25 == (x * 5243) >> 17 for x below 43690
    localparam logic [12:0] RECIP_25 = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 17;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FORMAT = 2'd1,
        STATUS_DIGIT  = 2'd2,
        STATUS_DATE   = 2'd3
    } status_t;

    // days from march 1 to the first of the month, indexed by month - 1
    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd306;
            4'd1:    d = 9'd337;
            4'd2:    d = 9'd0;
            4'd3:    d = 9'd31;
            4'd4:    d = 9'd61;
            4'd5:    d = 9'd92;
            4'd6:    d = 9'd122;
            4'd7:    d = 9'd153;
            4'd8:    d = 9'd184;
            4'd9:    d = 9'd214;
            4'd10:   d = 9'd245;
            4'd11:   d = 9'd275;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] idx);
        logic [4:0] d;
        case (idx)
            4'd1:    d = 5'd28;
            4'd3:    d = 5'd30;
            4'd5:    d = 5'd30;
            4'd8:    d = 5'd30;
            4'd10:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/iso_hour_timestamp_parser.sv
// Parses a YYYY-MM-DDTHH:00 timestamp arriving one character per transfer and
// returns the signed hour count since 1970-01-01T00 UTC with a status. A
// character is taken every cycle while s_ready is high. After the transfer of
// the last character the fields pass through a conversion pipeline
// of four registers: operand prep, reciprocal multiplies for the century and
// era divisions, day sum and checks, and hour scaling into the output
// register. Each stage holds its own item, so conversions overlap with the
// parsing of the next timestamp. The input keeps moving while results wait
// on m_ready, until all four stages hold a waiting result; s_ready then stays
// low until m_ready frees a stage.
module iso_hour_timestamp_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [27:0] m_hours_since_epoch,
    output logic [1:0]  m_status,
    input  logic        cfg_wr_en,
    input  logic [13:0] cfg_wr_data
);

    localparam int unsigned YW = ihtp_pkg::YEAR_W;
    localparam int unsigned FW = ihtp_pkg::FIELD_W;
    localparam int unsigned PW = ihtp_pkg::POS_W;
    localparam int unsigned DW = ihtp_pkg::DAYS_W;
    localparam int unsigned HW = ihtp_pkg::HOURS_W;

    logic [YW-1:0] earliest_reg;

    // parse state
    logic [PW-1:0] pos_reg, pos_next;
    logic [YW-1:0] year_reg, year_next;
    logic [FW-1:0] month_reg, month_next;
    logic [FW-1:0] day_reg, day_next;
    logic [FW-1:0] hour_reg, hour_next;
    logic          fmt_reg, fmt_next;
    logic          dig_reg, dig_next;

    logic       is_digit;
    logic [3:0] digit;
    logic       s_xfer;

    // pipeline handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, m_valid_reg;
    logic s1_ready, s2_ready, s3_ready, out_ready;

    // stage 1: finished fields
    logic [YW-1:0] s1_year_reg;
    logic [FW-1:0] s1_month_reg, s1_day_reg, s1_hour_reg;
    logic          s1_fmt_reg, s1_dig_reg;

    // stage 2: products
    logic [YW-1:0] yp;
    logic [21:0]   yp365;
    logic [23:0]   p100;
    logic [21:0]   p400;
    logic [23:0]   pleap;
    logic [21:0]   s2_yp365_reg;
    logic [11:0]   s2_q4_reg;
    logic [23:0]   s2_p100_reg;
    logic [21:0]   s2_p400_reg;
    logic [23:0]   s2_pleap_reg;
    logic [YW-1:0] s2_year_reg;
    logic [FW-1:0] s2_month_reg, s2_day_reg, s2_hour_reg;
    logic          s2_fmt_reg, s2_dig_reg;

    // stage 3: day count and status
    logic [6:0]    q100;
    logic [4:0]    q400;
    logic [6:0]    qleap;
    logic [3:0]    midx;
    logic          leap;
    logic [5:0]    mlen;
    logic          bad_date;
    logic [DW-1:0] days;
    ihtp_pkg::status_t status;
    logic [DW-1:0] s3_days_reg;
    logic [FW-1:0] s3_hour_reg;
    ihtp_pkg::status_t s3_status_reg;

    // stage 4: output
    logic [HW-1:0] days_ext;
    logic [HW-1:0] hours;
    logic [HW-1:0] m_hours_reg;
    ihtp_pkg::status_t m_status_reg;

    assign out_ready = !m_valid_reg || m_ready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_ready   = s1_ready;
    assign s_xfer    = s_valid && s_ready;

    assign is_digit = (s_char_in >= ihtp_pkg::CHAR_ZERO) && (s_char_in <= ihtp_pkg::CHAR_NINE);
    assign digit    = s_char_in[3:0];

    always_comb begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        hour_next  = hour_reg;
        fmt_next   = fmt_reg;
        dig_next   = dig_reg;
        if (pos_reg >= ihtp_pkg::TS_LENGTH) begin
            fmt_next = 1'b1;
        end else begin
            case (pos_reg)
                ihtp_pkg::POS_DATE_SEP1, ihtp_pkg::POS_DATE_SEP2: begin
                    if (s_char_in != ihtp_pkg::CHAR_DASH) fmt_next = 1'b1;
                end
                ihtp_pkg::POS_TIME_SEP: begin
                    if (s_char_in != ihtp_pkg::CHAR_T) fmt_next = 1'b1;
                end
                ihtp_pkg::POS_HOUR_SEP: begin
                    if (s_char_in != ihtp_pkg::CHAR_COLON) fmt_next = 1'b1;
                end
                ihtp_pkg::POS_MIN_TENS, ihtp_pkg::POS_MIN_ONES: begin
                    if (s_char_in != ihtp_pkg::CHAR_ZERO) fmt_next = 1'b1;
                end
                default: begin
                    if (!is_digit) begin
                        dig_next = 1'b1;
                    end else if (pos_reg <= ihtp_pkg::POS_YEAR_END) begin
                        year_next = year_reg * 14'd10 + {10'd0, digit};
                    end else if (pos_reg <= ihtp_pkg::POS_MON_END) begin
                        month_next = month_reg * 7'd10 + {3'd0, digit};
                    end else if (pos_reg <= ihtp_pkg::POS_DAY_END) begin
                        day_next = day_reg * 7'd10 + {3'd0, digit};
                    end else begin
                        hour_next = hour_reg * 7'd10 + {3'd0, digit};
                    end
                end
            endcase
        end
        pos_next = (pos_reg < ihtp_pkg::TS_LENGTH) ? pos_reg + 5'd1 : pos_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            earliest_reg <= ihtp_pkg::EARLIEST_YEAR_RESET;
        end else if (cfg_wr_en) begin
            earliest_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            year_reg  <= '0;
            month_reg <= '0;
            day_reg   <= '0;
            hour_reg  <= '0;
            fmt_reg   <= 1'b0;
            dig_reg   <= 1'b0;
        end else if (s_xfer) begin
            if (s_last) begin
                pos_reg   <= '0;
                year_reg  <= '0;
                month_reg <= '0;
                day_reg   <= '0;
                hour_reg  <= '0;
                fmt_reg   <= 1'b0;
                dig_reg   <= 1'b0;
            end else begin
                pos_reg   <= pos_next;
                year_reg  <= year_next;
                month_reg <= month_next;
                day_reg   <= day_next;
                hour_reg  <= hour_next;
                fmt_reg   <= fmt_next;
                dig_reg   <= dig_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_ready) s1_valid_reg <= s_xfer && s_last;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (out_ready) m_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1 load
    always_ff @(posedge aclk) begin
        if (s_xfer && s_last) begin
            s1_year_reg  <= year_next;
            s1_month_reg <= month_next;
            s1_day_reg   <= day_next;
            s1_hour_reg  <= hour_next;
            s1_fmt_reg   <= fmt_next || (pos_next != ihtp_pkg::TS_LENGTH);
            s1_dig_reg   <= dig_next;
        end
    end

    // january and february count with the previous year
    assign yp    = s1_year_reg + ihtp_pkg::YEAR_BIAS - {13'd0, (s1_month_reg <= 7'd2)};
    assign yp365 = 22'(yp) * 22'd365;
    assign p100  = 24'(yp[13:2]) * 24'(ihtp_pkg::RECIP_25);
    assign p400  = 22'(yp[13:4]) * 22'(ihtp_pkg::RECIP_25);
    assign pleap = 24'(s1_year_reg[13:2]) * 24'(ihtp_pkg::RECIP_25);

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_yp365_reg <= yp365;
            s2_q4_reg    <= yp[13:2];
            s2_p100_reg  <= p100;
            s2_p400_reg  <= p400;
            s2_pleap_reg <= pleap;
            s2_year_reg  <= s1_year_reg;
            s2_month_reg <= s1_month_reg;
            s2_day_reg   <= s1_day_reg;
            s2_hour_reg  <= s1_hour_reg;
            s2_fmt_reg   <= s1_fmt_reg;
            s2_dig_reg   <= s1_dig_reg;
        end
    end

    assign q100  = s2_p100_reg[23:ihtp_pkg::RECIP_SHIFT];
    assign q400  = s2_p400_reg[21:ihtp_pkg::RECIP_SHIFT];
    assign qleap = s2_pleap_reg[23:ihtp_pkg::RECIP_SHIFT];
    assign midx  = 4'(s2_month_reg - 7'd1);

    // a multiple of four is a leap year unless it is a century not divisible by 400
    assign leap = (s2_year_reg[1:0] == 2'b00)
               && ((s2_year_reg != 14'(qleap) * 14'd100) || (qleap[1:0] == 2'b00));
    assign mlen = {1'b0, ihtp_pkg::month_days(midx)}
               + {5'd0, (s2_month_reg == 7'd2) && leap};

    assign bad_date = (s2_year_reg < earliest_reg)
                   || (s2_month_reg == 7'd0) || (s2_month_reg > 7'd12)
                   || (s2_day_reg == 7'd0) || (s2_hour_reg > 7'd23)
                   || ({1'b0, s2_day_reg} > {2'b00, mlen});

    assign days = 24'(s2_yp365_reg) + 24'(s2_q4_reg) - 24'(q100) + 24'(q400)
                + 24'(ihtp_pkg::days_before_month(midx)) + 24'(s2_day_reg)
                - 24'd1 - ihtp_pkg::EPOCH_BIAS;

    always_comb begin
        if (s2_fmt_reg) begin
            status = ihtp_pkg::STATUS_FORMAT;
        end else if (s2_dig_reg) begin
            status = ihtp_pkg::STATUS_DIGIT;
        end else if (bad_date) begin
            status = ihtp_pkg::STATUS_DATE;
        end else begin
            status = ihtp_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && s2_valid_reg) begin
            s3_days_reg   <= days;
            s3_hour_reg   <= s2_hour_reg;
            s3_status_reg <= status;
        end
    end

    assign days_ext = {{(HW-DW){s3_days_reg[DW-1]}}, s3_days_reg};
    assign hours    = (days_ext << 4) + (days_ext << 3) + 28'(s3_hour_reg);

    always_ff @(posedge aclk) begin
        if (out_ready && s3_valid_reg) begin
            m_hours_reg  <= (s3_status_reg == ihtp_pkg::STATUS_OK) ? hours : '0;
            m_status_reg <= s3_status_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_hours_since_epoch = $signed(m_hours_reg);
    assign m_status            = m_status_reg;

    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= ihtp_pkg::TS_LENGTH)
        else $error("position counter past timestamp length");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> (pos_reg == '0) && !fmt_reg && !dig_reg)
        else $error("parse state not cleared after last transfer");

    a_stage1_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s1_valid_reg) |-> $past(s_valid && s_ready && s_last))
        else $error("conversion started without a last transfer");

    a_error_zero_hours: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ihtp_pkg::STATUS_OK) |-> (m_hours_since_epoch == '0))
        else $error("nonzero hour count with error status");

endmodule

// File: sim/tb_iso_hour_timestamp_parser.sv
`timescale 1ns / 1ps

module tb_iso_hour_timestamp_parser;

    localparam int unsigned YW = ihtp_pkg::YEAR_W;
    localparam int unsigned FW = ihtp_pkg::FIELD_W;
    localparam int unsigned PW = ihtp_pkg::POS_W;
    localparam int unsigned HW = ihtp_pkg::HOURS_W;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic signed [HW-1:0] hours;
        ihtp_pkg::status_t    status;
    } stamp_result_t;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned NUM_PHASES   = 5;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_char_in = 8'h00;
    logic                 s_last = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [HW-1:0] m_hours_since_epoch;
    logic [1:0]           m_status;
    logic                 cfg_wr_en = 1'b0;
    logic [YW-1:0]        cfg_wr_data = '0;

    // parser copy kept by the bench
    logic [PW-1:0] pos_cnt = '0;
    logic [YW-1:0] year_acc = '0;
    logic [FW-1:0] month_acc = '0;
    logic [FW-1:0] day_acc = '0;
    logic [FW-1:0] hour_acc = '0;
    bit            fmt_err = 1'b0;
    bit            digit_err = 1'b0;
    logic [YW-1:0] floor_year = ihtp_pkg::EARLIEST_YEAR_RESET;

    int unsigned month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    char_item_t    char_q[$];
    logic [7:0]    text_buf[$];
    stamp_result_t pending_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned chars_queued = 0;
    int unsigned chars_taken = 0;
    int unsigned results_seen = 0;
    int unsigned errors = 0;
    int unsigned cycle_cnt = 0;
    logic        s_fire = 1'b0;

    iso_hour_timestamp_parser dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_char_in           (s_char_in),
        .s_last              (s_last),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_hours_since_epoch (m_hours_since_epoch),
        .m_status            (m_status),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        return month_len[m-1] + ((m == 2 && leap) ? 1 : 0);
    endfunction

    // gregorian day number relative to 1970-01-01, eras of 400 years
    function automatic longint epoch_day_count(input longint y, input longint m,
                                               input longint d);
        longint era, yoe, mp, doy;
        if (m <= 2) y = y - 1;
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        mp  = (m > 2) ? m - 3 : m + 9;
        doy = (153 * mp + 2) / 5 + d - 1;
        return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
    endfunction

    // advance the parser by one character; returns 1 when a result is due
    function automatic bit parse_char(input logic [7:0] c, input logic lst,
                                      output stamp_result_t res);
        bit          is_dig;
        bit          bad;
        int unsigned dv, y, m, d, h;
        is_dig = (c >= ihtp_pkg::CHAR_ZERO) && (c <= ihtp_pkg::CHAR_NINE);
        dv = is_dig ? int'(c - ihtp_pkg::CHAR_ZERO) : 0;
        res.hours = '0;
        res.status = ihtp_pkg::STATUS_OK;
        if (pos_cnt >= ihtp_pkg::TS_LENGTH) begin
            fmt_err = 1'b1;
        end else if (pos_cnt == ihtp_pkg::POS_DATE_SEP1 || pos_cnt == ihtp_pkg::POS_DATE_SEP2) begin
            if (c != ihtp_pkg::CHAR_DASH) fmt_err = 1'b1;
        end else if (pos_cnt == ihtp_pkg::POS_TIME_SEP) begin
            if (c != ihtp_pkg::CHAR_T) fmt_err = 1'b1;
        end else if (pos_cnt == ihtp_pkg::POS_HOUR_SEP) begin
            if (c != ihtp_pkg::CHAR_COLON) fmt_err = 1'b1;
        end else if (pos_cnt == ihtp_pkg::POS_MIN_TENS || pos_cnt == ihtp_pkg::POS_MIN_ONES) begin
            if (c != ihtp_pkg::CHAR_ZERO) fmt_err = 1'b1;
        end else if (!is_dig) begin
            digit_err = 1'b1;
        end else if (pos_cnt <= ihtp_pkg::POS_YEAR_END) begin
            year_acc = YW'(year_acc * 10 + dv);
        end else if (pos_cnt <= ihtp_pkg::POS_MON_END) begin
            month_acc = FW'(month_acc * 10 + dv);
        end else if (pos_cnt <= ihtp_pkg::POS_DAY_END) begin
            day_acc = FW'(day_acc * 10 + dv);
        end else begin
            hour_acc = FW'(hour_acc * 10 + dv);
        end
        if (pos_cnt < ihtp_pkg::TS_LENGTH) pos_cnt = pos_cnt + 1'b1;
        if (!lst) return 1'b0;

        if (fmt_err || pos_cnt != ihtp_pkg::TS_LENGTH) begin
            res.status = ihtp_pkg::STATUS_FORMAT;
        end else if (digit_err) begin
            res.status = ihtp_pkg::STATUS_DIGIT;
        end else begin
            y = year_acc;
            m = month_acc;
            d = day_acc;
            h = hour_acc;
            bad = (y < floor_year) || (m < 1) || (m > 12) || (d < 1) || (h > 23);
            if (!bad && d > days_in_month(y, m)) bad = 1'b1;
            if (bad) begin
                res.status = ihtp_pkg::STATUS_DATE;
            end else begin
                res.hours = HW'(epoch_day_count(y, m, d) * 24 + h);
            end
        end
        pos_cnt   = '0;
        year_acc  = '0;
        month_acc = '0;
        day_acc   = '0;
        hour_acc  = '0;
        fmt_err   = 1'b0;
        digit_err = 1'b0;
        return 1'b1;
    endfunction

    // sender side: next character goes out once the current one has transferred
    always @(negedge aclk) begin
        char_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_fire) begin
                if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = char_q.pop_front();
                    s_valid   <= 1'b1;
                    s_char_in <= nxt.ch;
                    s_last    <= nxt.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        stamp_result_t got_exp;
        stamp_result_t want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
        if (!aresetn) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got hours %0d status %0d",
                             $time, m_hours_since_epoch, m_status);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    results_seen++;
                    if (m_hours_since_epoch !== want.hours) begin
                        $display("%0t: hours mismatch, expected %0d, got %0d",
                                 $time, want.hours, m_hours_since_epoch);
                        errors++;
                    end
                    if (m_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, m_status);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                chars_taken++;
                if (parse_char(s_char_in, s_last, got_exp)) begin
                    pending_results.insert(pending_results.size(), got_exp);
                end
            end
        end
    end

    task automatic add_char(input logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endtask

    task automatic put_digits(input int unsigned v, input int unsigned ndig);
        int unsigned scale;
        scale = 1;
        repeat (ndig - 1) scale *= 10;
        repeat (ndig) begin
            add_char(ihtp_pkg::CHAR_ZERO + 8'((v / scale) % 10));
            scale /= 10;
        end
    endtask

    task automatic build_stamp(input int unsigned y, input int unsigned m,
                               input int unsigned d, input int unsigned h);
        text_buf.delete();
        put_digits(y, 4);
        add_char(ihtp_pkg::CHAR_DASH);
        put_digits(m, 2);
        add_char(ihtp_pkg::CHAR_DASH);
        put_digits(d, 2);
        add_char(ihtp_pkg::CHAR_T);
        put_digits(h, 2);
        add_char(ihtp_pkg::CHAR_COLON);
        add_char(ihtp_pkg::CHAR_ZERO);
        add_char(ihtp_pkg::CHAR_ZERO);
    endtask

    // hand the text over to the sender, last flag on its final character
    task automatic flush_text();
        char_item_t item;
        foreach (text_buf[i]) begin
            item.ch   = text_buf[i];
            item.last = (i == text_buf.size() - 1);
            char_q.insert(char_q.size(), item);
        end
        chars_queued += text_buf.size();
        text_buf.delete();
    endtask

    task automatic random_stamps(input int unsigned n_chars);
        int unsigned start_cnt, y, m, d, h, kind, n;
        int          t;
        start_cnt = chars_queued;
        while (chars_queued - start_cnt < n_chars) begin
            kind = $urandom_range(99);
            case ($urandom_range(3))
                0: begin
                    // around the year floor
                    t = int'(floor_year) + int'($urandom_range(4)) - 2;
                    if (t < 0) t = 0;
                    if (t > 9999) t = 9999;
                    y = t;
                end
                1:       y = $urandom_range(9999);
                default: y = $urandom_range(1900, 2100);
            endcase
            if ($urandom_range(9) != 0) m = $urandom_range(1, 12);
            else m = $urandom_range(1) ? 0 : $urandom_range(13, 99);
            case ($urandom_range(19))
                0:       d = 0;
                1:       d = (m >= 1 && m <= 12) ? days_in_month(y, m) + 1 : 32;
                2:       d = $urandom_range(32, 99);
                default: d = (m >= 1 && m <= 12) ? $urandom_range(1, days_in_month(y, m))
                                                 : $urandom_range(1, 31);
            endcase
            h = ($urandom_range(19) == 0) ? $urandom_range(24, 99) : $urandom_range(23);
            if (kind < 8) begin
                // leap day probes, century years included
                y = $urandom_range(1) ? 100 * $urandom_range(99) : $urandom_range(9999);
                m = 2;
                d = $urandom_range(28, 30);
            end
            build_stamp(y, m, d, h);
            if (kind >= 60 && kind < 75) begin
                text_buf[$urandom_range(15)] = 8'($urandom);
            end else if (kind >= 75 && kind < 80) begin
                text_buf[$urandom_range(14, 15)] = ihtp_pkg::CHAR_ZERO
                                                 + 8'($urandom_range(1, 9));
            end else if (kind >= 80 && kind < 88) begin
                n = $urandom_range(1, 15);
                while (text_buf.size() > n) text_buf.delete(text_buf.size() - 1);
            end else if (kind >= 88 && kind < 94) begin
                repeat ($urandom_range(1, 8)) add_char(8'($urandom));
            end else if (kind >= 94) begin
                text_buf.delete();
                repeat ($urandom_range(1, 20)) add_char(8'($urandom));
            end
            flush_text();
        end
    endtask

    task automatic wait_idle();
        while (chars_taken != chars_queued || pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_floor(input logic [YW-1:0] yr);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= yr;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        floor_year = yr;
    endtask

    initial begin
        int unsigned ph;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1: begin send_idle_pct = 60; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 60; end
                3: begin send_idle_pct = 25; stall_pct = 25; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            case (ph)
                0: begin
                    // latest possible hour, then stamps of one and two characters with the length wrong
                    build_stamp(9999, 12, 31, 23);
                    flush_text();
                    add_char(8'hFF);
                    flush_text();
                    add_char(8'h00);
                    add_char(ihtp_pkg::CHAR_NINE);
                    flush_text();
                end
                1: begin
                    set_floor('0);
                    // earliest possible hour, year zero
                    build_stamp(0, 1, 1, 0);
                    flush_text();
                end
                2: set_floor(YW'($urandom_range(1, 9998)));
                3: set_floor(14'd9999);
                default: set_floor('1);
            endcase
            random_stamps((ph == NUM_PHASES - 1) ? 80 : 160);
            wait_idle();
        end

        $display("covered %0d characters and %0d timestamp results", chars_taken, results_seen);
        $display("over %0d year floor settings and four idle patterns", NUM_PHASES);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
